// ===== rtl/sv39_ptw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the Sv39 page table walker.
// No dependencies; used by every module of the walker.
package sv39_ptw_pkg;

  localparam int unsigned PT_PAGES       = 64;
  localparam int unsigned WORDS_PER_PAGE = 512;
  localparam int unsigned STORE_WORDS    = PT_PAGES * WORDS_PER_PAGE;
  localparam int unsigned MEM_AW         = $clog2(STORE_WORDS);
  localparam int unsigned PPN_W          = 44;
  localparam int unsigned VA_W           = 39;
  localparam int unsigned VPN_W          = 9;
  localparam int unsigned IDX_W          = 15;
  localparam int unsigned PTE_W          = 64;
  localparam int unsigned LVL_W          = 2;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned Q_AW           = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CW           = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IN_DATA_W      = 120;
  localparam int unsigned OUT_DATA_W     = 72;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic                oos;
    logic [MEM_AW-1:0]   addr;
    logic [PTE_W-1:0]    word;
    logic [VA_W-1:0]     va;
  } cmd_t;

  function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                              input logic [LVL_W-1:0] lvl);
    logic [VPN_W-1:0] v;
    case (lvl)
      2'd2:    v = va[38:30];
      2'd1:    v = va[29:21];
      default: v = va[20:12];
    endcase
    return v;
  endfunction

  function automatic logic [MEM_AW-1:0] tbl_addr(input logic [PPN_W-1:0] ppn,
                                                 input logic [VPN_W-1:0] vpn);
    logic [PPN_W+VPN_W-1:0] full;
    full = {ppn, vpn};
    return full[MEM_AW-1:0];
  endfunction

endpackage

// ===== rtl/sv39_ptw_front.sv =====
`timescale 1ns / 1ps
// Input side: accepts stream words, classifies them into walker commands.
// Depends on sv39_ptw_pkg.
module sv39_ptw_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sv39_ptw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                clear_busy_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output sv39_ptw_pkg::cmd_t                  cmd_o
);

  logic [sv39_ptw_pkg::IDX_W-1:0] store_index;
  logic                           busy_q;
  logic                           busy_d;

  // hold off the first word until the store wipe has been seen
  assign busy_d = clear_busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign store_index   = s_axis_tdata[14:0];
  assign s_axis_tready = !busy_q && !clear_busy_i && !q_full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd_o.op   = sv39_ptw_pkg::op_e'(s_axis_tuser);
    cmd_o.oos  = (32'(store_index) >= sv39_ptw_pkg::STORE_WORDS);
    cmd_o.addr = sv39_ptw_pkg::MEM_AW'(store_index);
    cmd_o.word = s_axis_tdata[78:15];
    cmd_o.va   = s_axis_tdata[117:79];
  end

endmodule

// ===== rtl/sv39_ptw_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back of the walker.
// Depends on sv39_ptw_pkg.
module sv39_ptw_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sv39_ptw_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output sv39_ptw_pkg::cmd_t cmd_o
);

  sv39_ptw_pkg::cmd_t                 slots_q [sv39_ptw_pkg::QUEUE_DEPTH];
  logic [sv39_ptw_pkg::Q_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sv39_ptw_pkg::Q_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sv39_ptw_pkg::Q_CW-1:0]      count_q, count_d;

  function automatic logic [sv39_ptw_pkg::Q_AW-1:0] bump(
      input logic [sv39_ptw_pkg::Q_AW-1:0] p);
    logic [sv39_ptw_pkg::Q_AW-1:0] n;
    if (p == sv39_ptw_pkg::Q_AW'(sv39_ptw_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign full_o  = (count_q == sv39_ptw_pkg::Q_CW'(sv39_ptw_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/sv39_ptw_back.sv =====
`timescale 1ns / 1ps
// Back end: table store, clearing pass, walk sequencer and result register.
// Depends on sv39_ptw_pkg.
module sv39_ptw_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]       root_ppn_i,
  input  logic                                 q_valid_i,
  input  sv39_ptw_pkg::cmd_t                   cmd_i,
  output logic                                 pop_o,
  output logic                                 clear_busy_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sv39_ptw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  sv39_ptw_pkg::state_e state_q, state_d;

  logic [sv39_ptw_pkg::PTE_W-1:0]  mem [sv39_ptw_pkg::STORE_WORDS];
  logic [sv39_ptw_pkg::PTE_W-1:0]  rdata_q;
  logic [sv39_ptw_pkg::MEM_AW-1:0] mem_addr;
  logic [sv39_ptw_pkg::PTE_W-1:0]  mem_wdata;
  logic                            mem_we;
  logic                            mem_re;

  logic [sv39_ptw_pkg::MEM_AW-1:0] clr_q, clr_d;
  logic [sv39_ptw_pkg::LVL_W-1:0]  lvl_q, lvl_d;
  logic [sv39_ptw_pkg::VA_W-1:0]   va_q, va_d;

  logic                            out_valid_q, out_valid_d;
  logic [sv39_ptw_pkg::PTE_W-1:0]  out_entry_q, out_entry_d;
  logic [sv39_ptw_pkg::LVL_W-1:0]  out_lvl_q, out_lvl_d;
  logic                            out_oos_q, out_oos_d;

  logic                            out_free;
  logic [sv39_ptw_pkg::PPN_W-1:0]  next_ppn;
  logic [sv39_ptw_pkg::LVL_W-1:0]  lvl_dn;
  logic                            leaf;

  assign out_free     = !out_valid_q || m_axis_tready;
  assign clear_busy_o = (state_q == sv39_ptw_pkg::ST_CLEAR);
  assign next_ppn     = rdata_q[53:10];
  assign lvl_dn       = lvl_q - 1'b1;
  assign leaf         = !rdata_q[0] || (rdata_q[3:1] != 3'b000) || (lvl_q == '0);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    va_d        = va_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_entry_d = out_entry_q;
    out_lvl_d   = out_lvl_q;
    out_oos_d   = out_oos_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = clr_q;
    mem_wdata   = '0;
    case (state_q)
      sv39_ptw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == sv39_ptw_pkg::MEM_AW'(sv39_ptw_pkg::STORE_WORDS - 1)) begin
          state_d = sv39_ptw_pkg::ST_IDLE;
        end
      end
      sv39_ptw_pkg::ST_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          if (cmd_i.op == sv39_ptw_pkg::OP_WRITE) begin
            out_valid_d = 1'b1;
            out_entry_d = '0;
            out_lvl_d   = '0;
            out_oos_d   = cmd_i.oos;
            mem_we      = !cmd_i.oos;
            mem_addr    = cmd_i.addr;
            mem_wdata   = cmd_i.word;
          end else begin
            va_d  = cmd_i.va;
            lvl_d = 2'd2;
            if (root_ppn_i >= sv39_ptw_pkg::PPN_W'(sv39_ptw_pkg::PT_PAGES)) begin
              out_valid_d = 1'b1;
              out_entry_d = '0;
              out_lvl_d   = 2'd2;
              out_oos_d   = 1'b1;
            end else begin
              mem_re   = 1'b1;
              mem_addr = sv39_ptw_pkg::tbl_addr(root_ppn_i,
                                                sv39_ptw_pkg::vpn_of(cmd_i.va, 2'd2));
              state_d  = sv39_ptw_pkg::ST_WALK;
            end
          end
        end
      end
      sv39_ptw_pkg::ST_WALK: begin
        if (leaf) begin
          out_valid_d = 1'b1;
          out_entry_d = rdata_q;
          out_lvl_d   = lvl_q;
          out_oos_d   = 1'b0;
          state_d     = sv39_ptw_pkg::ST_IDLE;
        end else if (next_ppn >= sv39_ptw_pkg::PPN_W'(sv39_ptw_pkg::PT_PAGES)) begin
          out_valid_d = 1'b1;
          out_entry_d = '0;
          out_lvl_d   = lvl_dn;
          out_oos_d   = 1'b1;
          state_d     = sv39_ptw_pkg::ST_IDLE;
        end else begin
          mem_re   = 1'b1;
          mem_addr = sv39_ptw_pkg::tbl_addr(next_ppn, sv39_ptw_pkg::vpn_of(va_q, lvl_dn));
          lvl_d    = lvl_dn;
        end
      end
      default: begin
        state_d = sv39_ptw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sv39_ptw_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q       <= lvl_d;
    va_q        <= va_d;
    out_entry_q <= out_entry_d;
    out_lvl_q   <= out_lvl_d;
    out_oos_q   <= out_oos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_oos_q, out_entry_q[0], out_lvl_q, out_entry_q};

endmodule

// ===== rtl/sv39_page_table_walk_top.sv =====
`timescale 1ns / 1ps
// Sv39 page table walker top level: config register, front, queue, back.
// Depends on sv39_ptw_pkg, sv39_ptw_front, sv39_ptw_queue, sv39_ptw_back.
//
// Usage:
//   s_axis: one word per item; tuser is the operation (0 write, 1 lookup).
//   m_axis: one result word per item, in order.
//   cfg: writes the root table page number; always ready.
// From input accept to result valid, a word passes through the queue into the back
// end, which registers the result directly for a write or for a lookup whose root
// page lies outside the store, and after reading one to three table words otherwise.
// Throughput: the back end pops one write per cycle while the output register is
// free; a lookup holds it until its walk ends, reading its table words one by one
// from the single-port table memory.
// Reset: all 32768 words of the table store are wiped one word per cycle while
// s_axis_tready stays low; the root page number resets to zero.
// Stall: a result waits in the output register while the two-entry queue
// keeps taking input words; s_axis_tready drops only when the queue fills.
module sv39_page_table_walk_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [14:0] store_index, [78:15] entry_word, [117:79] virtual_address
  input  logic [sv39_ptw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] operation
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [63:0] found_entry, [65:64] found_level, [66] entry_valid, [67] out_of_store
  output logic [sv39_ptw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sv39_ptw_pkg::PPN_W-1:0]       cfg_data_i
);

  logic [sv39_ptw_pkg::PPN_W-1:0] root_ppn_q, root_ppn_d;
  sv39_ptw_pkg::cmd_t             push_cmd;
  sv39_ptw_pkg::cmd_t             head_cmd;
  logic                           push;
  logic                           pop;
  logic                           q_full;
  logic                           q_valid;
  logic                           clear_busy;

  assign cfg_ready_o = 1'b1;
  assign root_ppn_d  = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : root_ppn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q <= '0;
    end else begin
      root_ppn_q <= root_ppn_d;
    end
  end

  sv39_ptw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clear_busy_i  (clear_busy),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  sv39_ptw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  sv39_ptw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .root_ppn_i    (root_ppn_q),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .clear_busy_o  (clear_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/sv39_ptw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the Sv39 walker top level, attached by bind.
// Depends on sv39_ptw_pkg and sv39_page_table_walk_top.
module sv39_ptw_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [sv39_ptw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[65:64] != 2'd3)
    else $error("found level out of range");

  a_valid_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[66] == m_axis_tdata[0])
    else $error("entry valid does not match entry bit 0");

  a_oos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[63:0] == '0)
    else $error("out of store result carries an entry");

  a_wipe_hold: assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready)
    else $error("input ready right after reset, before store wipe");

endmodule

bind sv39_page_table_walk_top sv39_ptw_checker u_sv39_ptw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv39_page_table_walk_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sv39_page_table_walk_top: table writes and Sv39 walks,
// checked word by word against an in-bench walker with its own copy of the store.
// Depends on sv39_ptw_pkg and the sv39_page_table_walk_top RTL.
module sv39_page_table_walk_top_test;
  import sv39_ptw_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PRESSURE_PHASE = 3;

  // found_entry lowest, as on m_axis_tdata
  typedef struct packed {
    logic             oos;
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [PTE_W-1:0] entry;
  } walk_t;

  typedef struct packed {
    bit               is_cfg;
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [PTE_W-1:0] word;
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] root;
    bit               typed;
    walk_t            want;
  } plan_row_t;

  typedef enum int {
    PTE_POINTER,
    PTE_LEAF,
    PTE_INVALID
  } pte_kind_e;

  localparam walk_t WROTE    = '0;
  localparam walk_t EMPTY_L2 = '{1'b0, 1'b0, 2'd2, 64'd0};
  localparam walk_t OOS_L2   = '{1'b1, 1'b0, 2'd2, 64'd0};
  localparam walk_t OOS_L1   = '{1'b1, 1'b0, 2'd1, 64'd0};

  localparam plan_row_t DIRECTED_PLAN [28] = '{
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'd0,             44'd0, 1'b1, EMPTY_L2},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h7F_FFFF_FFFF,  44'd0, 1'b1, EMPTY_L2},
    '{1'b0, OP_WRITE,  15'd0,     '1,                     39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_WRITE,  15'd32767, 64'h8000_0000_0000_0001, 39'd0,            44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'd0,             44'd0, 1'b1,
      '{1'b0, 1'b1, 2'd2, '1}},
    '{1'b0, OP_WRITE,  15'd1,     64'h401,                39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_4000_0000,  44'd0, 1'b0, WROTE},
    // pointer with junk above bit 53 and in bits 4..9
    '{1'b0, OP_WRITE,  15'd512,   64'hFFC0_0000_0000_0BF1, 39'd0,            44'd0, 1'b1, WROTE},
    '{1'b0, OP_WRITE,  15'd1029,  64'h0000_0000_1234_5CFF, 39'd0,            44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_4000_5ABC,  44'd0, 1'b0, WROTE},
    // valid pointer reached at level 0 ends the walk
    '{1'b0, OP_WRITE,  15'd1030,  64'hC01,                39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_4000_6000,  44'd0, 1'b0, WROTE},
    '{1'b0, OP_WRITE,  15'd2,     64'h1_0001,             39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_8000_0000,  44'd0, 1'b1, OOS_L1},
    '{1'b0, OP_WRITE,  15'd3,     64'h003F_FFFF_FFFF_FC01, 39'd0,            44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_C000_0000,  44'd0, 1'b1, OOS_L1},
    '{1'b0, OP_WRITE,  15'd519,   64'h3,                  39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h00_40E0_0000,  44'd0, 1'b1,
      '{1'b0, 1'b1, 2'd1, 64'h3}},
    '{1'b0, OP_WRITE,  15'd4,     64'hE,                  39'd0,             44'd0, 1'b1, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h01_0000_0000,  44'd0, 1'b1,
      '{1'b0, 1'b0, 2'd2, 64'hE}},
    '{1'b1, OP_WRITE,  15'd0,     64'd0,                  39'd0,             44'd63, 1'b0, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'd0,             44'd0, 1'b1, EMPTY_L2},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h7F_FFFF_FFFF,  44'd0, 1'b0, WROTE},
    '{1'b1, OP_WRITE,  15'd0,     64'd0,                  39'd0,             44'd64, 1'b0, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h2A_5555_AAAA,  44'd0, 1'b1, OOS_L2},
    '{1'b1, OP_WRITE,  15'd0,     64'd0,                  39'd0,             '1,    1'b0, WROTE},
    '{1'b0, OP_LOOKUP, 15'd0,     64'd0,                  39'h55_AAAA_5555,  44'd0, 1'b1, OOS_L2},
    '{1'b1, OP_WRITE,  15'd0,     64'd0,                  39'd0,             44'd0, 1'b0, WROTE}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [14:0] store_index, [78:15] entry_word, [117:79] va
  logic                  s_axis_tuser;   // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [63:0] entry, [65:64] level, [66] valid, [67] oos
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [PPN_W-1:0]      cfg_data_i;

  bit [PTE_W-1:0]   store_mirror [STORE_WORDS];
  logic [PPN_W-1:0] root_mirror = '0;
  walk_t            pending_walks [$];

  bit src_idle     = 1'b1;
  bit sink_idle    = 1'b1;
  bit hold_request = 1'b0;
  int fail_count   = 0;
  int cycle_count  = 0;
  int items_sent   = 0;
  int writes_sent  = 0;
  int walks_sent   = 0;
  int roots_used   = 0;
  int oos_walks    = 0;
  int level_stops [3] = '{0, 0, 0};

  sv39_page_table_walk_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sv39_page_table_walk_top regression: fail");
      $finish;
    end
  end

  // Applies one item to the mirror store and returns the walk result.
  function automatic walk_t predict_walk(input op_e op, input logic [IDX_W-1:0] idx,
                                         input logic [PTE_W-1:0] word,
                                         input logic [VA_W-1:0] va);
    walk_t            r;
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] pte;
    logic [VPN_W-1:0] vpn;
    int               lvl;
    r = '0;
    if (op == OP_WRITE) begin
      if (idx < STORE_WORDS) store_mirror[idx] = word;
      else r.oos = 1'b1;
      return r;
    end
    ppn = root_mirror;
    for (lvl = 2; lvl >= 0; lvl--) begin
      r.level = LVL_W'(lvl);
      if (ppn >= PT_PAGES) begin
        r.oos = 1'b1;
        return r;
      end
      vpn = va[12 + 9 * lvl +: 9];
      pte = store_mirror[int'(ppn) * WORDS_PER_PAGE + int'(vpn)];
      if (!pte[0] || pte[3:1] != 3'b000 || lvl == 0) begin
        r.entry = pte;
        r.valid = pte[0];
        return r;
      end
      ppn = pte[53:10];
    end
    return r;
  endfunction

  function automatic logic [PTE_W-1:0] random_pte();
    logic [PTE_W-1:0] w;
    pte_kind_e        kind;
    int               pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    kind = (pick < 12) ? PTE_POINTER : (pick < 17) ? PTE_LEAF : PTE_INVALID;
    case (kind)
      PTE_POINTER: begin
        if ($urandom_range(0, 7) == 0) w[53:10] = PPN_W'({$urandom, $urandom}) | PPN_W'(PT_PAGES);
        else w[53:10] = PPN_W'($urandom_range(0, PT_PAGES - 1));
        w[3:1] = 3'b000;
        w[0]   = 1'b1;
      end
      PTE_LEAF: begin
        w[0] = 1'b1;
        if (w[3:1] == 3'b000) w[1] = 1'b1;
      end
      default: w[0] = 1'b0;
    endcase
    return w;
  endfunction

  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [PTE_W-1:0] word, input logic [VA_W-1:0] va,
                           input bit typed = 1'b0, input walk_t want = '0);
    walk_t predicted;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({va, word, idx});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_walk(op, idx, word, va);
    if (typed) predicted = want;
    pending_walks.push_back(predicted);
    items_sent++;
    if (op == OP_WRITE) begin
      writes_sent++;
    end else begin
      walks_sent++;
      if (predicted.oos) oos_walks++;
      else level_stops[predicted.level]++;
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] word);
    send_item(OP_WRITE, idx, word, VA_W'({$urandom, $urandom}));
  endtask

  task automatic lookup(input logic [VA_W-1:0] va);
    send_item(OP_LOOKUP, IDX_W'($urandom), {$urandom, $urandom}, va);
  endtask

  // Only while nothing is in flight.
  task automatic set_root(input logic [PPN_W-1:0] ppn);
    s_axis_tvalid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ppn;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    root_mirror = ppn;
    roots_used++;
  endtask

  // Lays down a table chain under a random address, walks it, then may walk a new level-0 VPN.
  task automatic build_and_walk();
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] pte;
    int               lvl;
    va  = VA_W'({$urandom, $urandom});
    ppn = root_mirror;
    for (lvl = 2; lvl >= 0 && ppn < PT_PAGES; lvl--) begin
      pte = random_pte();
      write_entry(IDX_W'(int'(ppn) * WORDS_PER_PAGE + int'(va[12 + 9 * lvl +: 9])), pte);
      if (!pte[0] || pte[3:1] != 3'b000) break;
      ppn = pte[53:10];
    end
    lookup(va);
    if ($urandom_range(0, 2) == 0) begin
      va[20:12] = VPN_W'($urandom);
      lookup(va);
    end
  endtask

  task automatic check_walk(input walk_t got);
    walk_t want;
    if (pending_walks.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      fail_count++;
      return;
    end
    want = pending_walks.pop_front();
    if (got.entry !== want.entry) begin
      $error("found_entry: expected %h, actual %h", want.entry, got.entry);
      fail_count++;
    end
    if (got.level !== want.level) begin
      $error("found_level: expected %0d, actual %0d", want.level, got.level);
      fail_count++;
    end
    if (got.valid !== want.valid) begin
      $error("entry_valid: expected %b, actual %b", want.valid, got.valid);
      fail_count++;
    end
    if (got.oos !== want.oos) begin
      $error("out_of_store: expected %b, actual %b", want.oos, got.oos);
      fail_count++;
    end
  endtask

  initial begin : result_sink
    int    stall;
    walk_t got;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(walk_t)-1:0];
        check_walk(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && sink_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int               phase;
    int               phase_end;
    int               pick;
    logic [PPN_W-1:0] next_root;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].is_cfg) set_root(DIRECTED_PLAN[i].root);
      else send_item(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].word,
                     DIRECTED_PLAN[i].va, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1:       next_root = '0;
        2:       next_root = PPN_W'(PT_PAGES - 1);
        4:       next_root = '1;
        6:       next_root = PPN_W'(PT_PAGES);
        default: next_root = PPN_W'($urandom_range(0, PT_PAGES - 1));
      endcase
      set_root(next_root);
      src_idle  = (phase != NUM_PHASES - 1) && (phase != PRESSURE_PHASE);
      sink_idle = (phase != NUM_PHASES - 1);
      if (phase == PRESSURE_PHASE) hold_request = 1'b1;
      phase_end = items_sent + ((next_root >= PT_PAGES) ? 25 : 150);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) build_and_walk();
        else if (pick < 8) lookup(VA_W'({$urandom, $urandom}));
        else write_entry(IDX_W'($urandom), {$urandom, $urandom});
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d table writes and %0d walks under %0d root page settings",
             writes_sent, walks_sent, roots_used);
    $display("walks ended at level 2/1/0: %0d/%0d/%0d, beyond the store: %0d",
             level_stops[2], level_stops[1], level_stops[0], oos_walks);
    if (fail_count == 0) begin
      $display("sv39_page_table_walk_top regression: pass");
    end else begin
      $display("sv39_page_table_walk_top regression: fail");
    end
    $finish;
  end

endmodule
